/* hdl/wdnp_pkg.sv */
package wdnp_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_LUMP  = 2'd0;
  localparam kind_t KIND_START = 2'd1;
  localparam kind_t KIND_MAP   = 2'd2;
  localparam kind_t KIND_END   = 2'd3;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_S          = 8'h53;
  localparam logic [7:0] CH_T          = 8'h54;
  localparam logic [7:0] CH_A          = 8'h41;
  localparam logic [7:0] CH_R          = 8'h52;
  localparam logic [7:0] CH_E          = 8'h45;
  localparam logic [7:0] CH_N          = 8'h4E;
  localparam logic [7:0] CH_D          = 8'h44;
  localparam logic [7:0] CH_M          = 8'h4D;
  localparam logic [7:0] CH_0          = 8'h30;
  localparam logic [7:0] CH_9          = 8'h39;

  localparam logic [7:0] MAP_COUNT_RST = 8'd10;

  localparam int NAME_BYTES = 8;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 104;

endpackage

/* hdl/wad_descriptor_nesting_parser_unit.sv */
// Directory descriptor nesting parser: one 16-byte descriptor in, one classified
// result out, at one request per clock sustained while the output side is ready.
// Each request passes an input register, name decode and stack update, and an
// output register. The top of the directory stack lives in a register; the entries
// below it sit in a small RAM that is read ahead, which is what lets a pop follow
// a push or another pop in the next cycle. No clearing pass is needed after reset.
module wad_descriptor_nesting_parser_unit import wdnp_pkg::*; #(
  parameter int MAX_DEPTH   = 16,
  parameter int MAX_ENTRIES = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,   // map_entry_count
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // elem_offset[31:0], elem_length[63:32], name_bytes[127:64]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]            in_tuser,    // start_of_list
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // entry_index[15:0], parent_index[31:16], parent_is_root[32], nest_depth[37:33],
  // out_offset[69:38], out_length[101:70], stack_overflow[102], unmatched_end[103]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser    // entry_kind
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH);
  localparam int IW = $clog2(MAX_ENTRIES);

  // input register
  logic                 in_v_r;
  logic [IN_DATA_W-1:0] in_data_r;
  logic                 in_sol_r;

  // output register
  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  kind_t                 out_kind_r;

  // parser state
  logic [7:0]    map_count_r;
  logic [LW-1:0] level_r, level_nxt;
  logic [7:0]    cd_r, cd_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0]   top_r, top_nxt;
  logic          byp_r;
  logic [15:0]   byp_data_r;

  logic          out_ok;
  logic          proc;
  kind_t         kind;
  logic [LW-1:0] level_eff;
  logic [7:0]    cd_eff;
  logic [IW-1:0] idx_eff;
  logic [15:0]   idx16;
  logic [15:0]   below;
  logic          ovf;
  logic          unm;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  assign out_ok    = !out_v_r || out_tready;
  assign proc      = in_v_r && out_ok;
  assign in_tready = !in_v_r || out_ok;

  wdnp_decode u_decode (
    .name (in_data_r[127:64]),
    .kind (kind)
  );

  assign level_eff = in_sol_r ? '0 : level_r;
  assign cd_eff    = in_sol_r ? 8'd0 : cd_r;
  assign idx_eff   = in_sol_r ? '0 : idx_r;
  assign idx16     = 16'(idx_eff);

  // entry just under the top; a push last cycle wrote exactly the read address
  assign below = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    level_nxt = level_r;
    cd_nxt    = cd_r;
    idx_nxt   = idx_r;
    top_nxt   = top_r;
    ovf       = 1'b0;
    unm       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(level_eff - LW'(1));
    if (proc) begin
      level_nxt = level_eff;
      cd_nxt    = cd_eff;
      idx_nxt   = (idx_eff == IW'(MAX_ENTRIES - 1)) ? '0 : idx_eff + IW'(1);
      unique case (kind)
        KIND_END: begin
          if (level_eff != '0) begin
            level_nxt = level_eff - LW'(1);
            top_nxt   = below;
          end else begin
            unm = 1'b1;
          end
        end
        KIND_START, KIND_MAP: begin
          if (level_eff < LW'(MAX_DEPTH)) begin
            level_nxt = level_eff + LW'(1);
            top_nxt   = idx16;
            ram_we    = (level_eff != '0);
          end else begin
            ovf = 1'b1;
          end
          if (kind == KIND_MAP) begin
            cd_nxt = map_count_r;
          end
        end
        default: begin
          if (cd_eff != 8'd0) begin
            cd_nxt = cd_eff - 8'd1;
            if (cd_eff == 8'd1 && level_eff != '0) begin
              level_nxt = level_eff - LW'(1);
              top_nxt   = below;
            end
          end
        end
      endcase
    end
  end

  // keep the ram output pointed at the entry under the next top
  assign ram_raddr = AW'(level_nxt - LW'(2));

  wdnp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      map_count_r <= MAP_COUNT_RST;
      level_r     <= '0;
      cd_r        <= 8'd0;
      idx_r       <= '0;
      byp_r       <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (proc) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        map_count_r <= cfg_wdata;
      end
      level_r <= level_nxt;
      cd_r    <= cd_nxt;
      idx_r   <= idx_nxt;
      byp_r   <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_sol_r  <= in_tuser[0];
    end
    top_r      <= top_nxt;
    byp_data_r <= top_r;
    if (proc) begin
      out_kind_r <= kind;
      out_data_r <= {unm, ovf, in_data_r[63:32], in_data_r[31:0], 5'(level_eff),
                     (level_eff == '0), (level_eff == '0) ? 16'd0 : top_r, idx16};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

/* hdl/wdnp_ram.sv */
module wdnp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/wdnp_decode.sv */
module wdnp_decode import wdnp_pkg::*; (
  input  logic [8*NAME_BYTES-1:0] name,
  output kind_t                   kind
);

  logic [7:0] b [NAME_BYTES];
  logic [3:0] len;
  logic       end_hit;
  logic       start_hit;
  logic       map_hit;

  always_comb begin
    for (int k = 0; k < NAME_BYTES; k++) begin
      b[k] = name[8*k +: 8];
    end
  end

  // name length is the position of the first zero byte
  always_comb begin
    len = 4'd8;
    for (int k = NAME_BYTES - 1; k >= 0; k--) begin
      if (b[k] == 8'h00) begin
        len = 4'(k);
      end
    end
  end

  always_comb begin
    end_hit   = 1'b0;
    start_hit = 1'b0;
    for (int l = 5; l <= NAME_BYTES; l++) begin
      if (len == 4'(l) && b[l-4] == CH_UNDERSCORE && b[l-3] == CH_E &&
          b[l-2] == CH_N && b[l-1] == CH_D) begin
        end_hit = 1'b1;
      end
    end
    for (int l = 7; l <= NAME_BYTES; l++) begin
      if (len == 4'(l) && b[l-6] == CH_UNDERSCORE && b[l-5] == CH_S &&
          b[l-4] == CH_T && b[l-3] == CH_A && b[l-2] == CH_R && b[l-1] == CH_T) begin
        start_hit = 1'b1;
      end
    end
    map_hit = (len == 4'd4) && (b[0] == CH_E) && (b[2] == CH_M) &&
              (b[1] >= CH_0) && (b[1] <= CH_9) && (b[3] >= CH_0) && (b[3] <= CH_9);
  end

  always_comb begin
    priority if (end_hit) begin
      kind = KIND_END;
    end else if (start_hit) begin
      kind = KIND_START;
    end else if (map_hit) begin
      kind = KIND_MAP;
    end else begin
      kind = KIND_LUMP;
    end
  end

endmodule
